// ===== hdl/block_sum_2x2_downsample_unit_assert.svh =====
// Assertion macros for the 2x2 sum pooling block.
`ifndef BLOCK_SUM_2X2_DOWNSAMPLE_UNIT_ASSERT_SVH
`define BLOCK_SUM_2X2_DOWNSAMPLE_UNIT_ASSERT_SVH

// Same-cycle implication, checked on clk, off while rst_n is low.
`define BSD_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bsd assertion failed");

// Next-cycle implication, checked on clk, off while rst_n is low.
`define BSD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bsd assertion failed");

`endif

// ===== hdl/bsd_pkg.sv =====
// Package: constants and types shared by the 2x2 sum pooling block.
`default_nettype none

package bsd_pkg;

  localparam int MAX_COLS   = 1024;
  localparam int MAX_ROWS   = 4096;
  localparam int DATA_BITS  = 16;

  localparam int PAIR_BITS  = DATA_BITS + 1;
  localparam int SUM_BITS   = DATA_BITS + 2;
  localparam int LINE_DEPTH = (MAX_COLS + 1) / 2;
  localparam int LINE_AW    = $clog2(LINE_DEPTH);
  localparam int COL_BITS   = $clog2(MAX_COLS);
  localparam int ROW_BITS   = $clog2(MAX_ROWS);

  // Configuration port
  localparam int ROWS_CFG_W = 13;
  localparam int COLS_CFG_W = 11;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_ROWS = 2'd0,
    CFG_FRAME_COLS = 2'd1
  } cfg_reg_t;

  // Per-beat decode from the position tracker
  typedef struct packed {
    logic               emit;
    logic               wr_en;
    logic               odd_row;
    logic               row_end;
    logic               frame_end;
    logic [LINE_AW-1:0] tile;
  } pos_t;

endpackage

`default_nettype wire

// ===== hdl/bsd_line_ram.sv =====
// Line store: one pair sum per tile column, one write and one registered read port.
`default_nettype none

module bsd_line_ram (
  input  wire logic                         clk,
  input  wire logic                         wr_en,
  input  wire logic [bsd_pkg::LINE_AW-1:0]  wr_addr,
  input  wire logic [bsd_pkg::PAIR_BITS-1:0] wr_data,
  input  wire logic                         rd_en,
  input  wire logic [bsd_pkg::LINE_AW-1:0]  rd_addr,
  output logic      [bsd_pkg::PAIR_BITS-1:0] rd_data
);

  logic [bsd_pkg::PAIR_BITS-1:0] mem [bsd_pkg::LINE_DEPTH];
  logic [bsd_pkg::PAIR_BITS-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== hdl/bsd_ctrl.sv =====
// Frame size registers, raster position counters and horizontal pair adder.
`default_nettype none

module bsd_ctrl (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_fire,
  input  wire logic [bsd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [bsd_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                           in_fire,
  input  wire logic signed [bsd_pkg::DATA_BITS-1:0] in_pixel,
  output bsd_pkg::pos_t                       pos,
  output logic [bsd_pkg::PAIR_BITS-1:0]       pair
);

  logic [bsd_pkg::ROW_BITS-1:0]  rows_m1_r, rows_m1_nxt;
  logic [bsd_pkg::COL_BITS-1:0]  cols_m1_r, cols_m1_nxt;
  logic [bsd_pkg::ROW_BITS-1:0]  row_index_r;
  logic [bsd_pkg::COL_BITS-1:0]  col_index_r;
  logic [bsd_pkg::PAIR_BITS-1:0] column_partial_r;

  logic [bsd_pkg::ROWS_CFG_W-1:0] rows_val;
  logic [bsd_pkg::COLS_CFG_W-1:0] cols_val;
  logic [bsd_pkg::PAIR_BITS-1:0]  px_ext;
  logic last_col, last_row, odd_col, odd_row, pair_done, restart;

  // Clamp sizes on write: zero acts as one, oversize acts as the maximum
  assign rows_val = cfg_data[bsd_pkg::ROWS_CFG_W-1:0];
  assign cols_val = cfg_data[bsd_pkg::COLS_CFG_W-1:0];

  always_comb begin
    priority if (rows_val == '0) begin
      rows_m1_nxt = '0;
    end else if (rows_val > bsd_pkg::ROWS_CFG_W'(bsd_pkg::MAX_ROWS)) begin
      rows_m1_nxt = bsd_pkg::ROW_BITS'(bsd_pkg::MAX_ROWS - 1);
    end else begin
      rows_m1_nxt = bsd_pkg::ROW_BITS'(rows_val - 1'b1);
    end
  end

  always_comb begin
    priority if (cols_val == '0) begin
      cols_m1_nxt = '0;
    end else if (cols_val > bsd_pkg::COLS_CFG_W'(bsd_pkg::MAX_COLS)) begin
      cols_m1_nxt = bsd_pkg::COL_BITS'(bsd_pkg::MAX_COLS - 1);
    end else begin
      cols_m1_nxt = bsd_pkg::COL_BITS'(cols_val - 1'b1);
    end
  end

  // Position decode for the current beat
  assign last_col  = (col_index_r >= cols_m1_r);
  assign last_row  = (row_index_r >= rows_m1_r);
  assign odd_col   = col_index_r[0];
  assign odd_row   = row_index_r[0];
  assign pair_done = odd_col || last_col;

  assign px_ext = {in_pixel[bsd_pkg::DATA_BITS-1], in_pixel};
  assign pair   = odd_col ? (column_partial_r + px_ext) : px_ext;

  assign pos.emit      = pair_done && (odd_row || last_row);
  assign pos.wr_en     = pair_done && !odd_row && !last_row;
  assign pos.odd_row   = odd_row;
  assign pos.row_end   = last_col;
  assign pos.frame_end = last_col && last_row;
  assign pos.tile      = col_index_r[bsd_pkg::COL_BITS-1:1];

  // Either size write restarts the frame
  assign restart = cfg_fire &&
                   ((cfg_index == bsd_pkg::CFG_FRAME_ROWS) ||
                    (cfg_index == bsd_pkg::CFG_FRAME_COLS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_m1_r        <= '0;
      cols_m1_r        <= '0;
      row_index_r      <= '0;
      col_index_r      <= '0;
      column_partial_r <= '0;
    end else if (restart) begin
      if (cfg_index == bsd_pkg::CFG_FRAME_ROWS) begin
        rows_m1_r <= rows_m1_nxt;
      end else begin
        cols_m1_r <= cols_m1_nxt;
      end
      row_index_r      <= '0;
      col_index_r      <= '0;
      column_partial_r <= '0;
    end else if (in_fire) begin
      if (!odd_col) begin
        column_partial_r <= px_ext;
      end
      if (last_col) begin
        col_index_r <= '0;
        row_index_r <= last_row ? '0 : row_index_r + 1'b1;
      end else begin
        col_index_r <= col_index_r + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/block_sum_2x2_downsample_unit.sv =====
// Top level: 2x2 stride-2 sum pooling over a raster pixel stream.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+---------------------------------
//  in      | input     | in_valid / in_stall | in_pixel (s16)
//  out     | output    | out_valid/out_stall | out_tile_sum (s18), row_end, frame_end
//  cfg     | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One pixel beat per cycle while out_stall does not back up; a tile sum leaves
// through the stage register and the line store read register, then the output register.
// Reset (rst_n low, synchronous) gives a 1x1 frame at position zero; the
// line store holds no data until the first even row writes it.
// out_stall backs up through the stage register into in_stall; cfg_ready is
// always high and a size write restarts the frame.
`default_nettype none
`include "block_sum_2x2_downsample_unit_assert.svh"

module block_sum_2x2_downsample_unit (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic signed [bsd_pkg::DATA_BITS-1:0] in_pixel,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic signed [bsd_pkg::SUM_BITS-1:0]       out_tile_sum,
  output logic                                      out_row_end,
  output logic                                      out_frame_end,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [bsd_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [bsd_pkg::CFG_DATA_W-1:0]       cfg_data
);

  bsd_pkg::pos_t                 pos;
  logic [bsd_pkg::PAIR_BITS-1:0] pair;
  logic [bsd_pkg::PAIR_BITS-1:0] line_rd;
  logic in_fire, cfg_fire, out_take;

  logic                          s1_valid_r;
  logic [bsd_pkg::PAIR_BITS-1:0] s1_pair_r;
  logic                          s1_odd_row_r;
  logic                          s1_row_end_r;
  logic                          s1_frame_end_r;

  logic                                out_valid_r;
  logic signed [bsd_pkg::SUM_BITS-1:0] out_sum_r, out_sum_nxt;
  logic                                out_row_end_r;
  logic                                out_frame_end_r;

  // Handshakes
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign out_take  = !out_valid_r || !out_stall;
  assign in_stall  = s1_valid_r && !out_take;
  assign in_fire   = in_valid && !in_stall;

  bsd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_fire  (cfg_fire),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_fire   (in_fire),
    .in_pixel  (in_pixel),
    .pos       (pos),
    .pair      (pair)
  );

  // Even rows, except a last row, write pair sums; odd rows read them back
  bsd_line_ram u_line (
    .clk     (clk),
    .wr_en   (in_fire && pos.wr_en),
    .wr_addr (pos.tile),
    .wr_data (pair),
    .rd_en   (in_fire),
    .rd_addr (pos.tile),
    .rd_data (line_rd)
  );

  // Stage register: beats that complete a tile
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= pos.emit;
    end else if (out_take) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_pair_r      <= pair;
      s1_odd_row_r   <= pos.odd_row;
      s1_row_end_r   <= pos.row_end;
      s1_frame_end_r <= pos.frame_end;
    end
  end

  // Vertical add: odd rows add the upper pair from the line store, else pair alone
  always_comb begin
    if (s1_odd_row_r) begin
      out_sum_nxt = $signed({line_rd[bsd_pkg::PAIR_BITS-1], line_rd}) +
                    $signed({s1_pair_r[bsd_pkg::PAIR_BITS-1], s1_pair_r});
    end else begin
      out_sum_nxt = $signed({s1_pair_r[bsd_pkg::PAIR_BITS-1], s1_pair_r});
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_take) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_take && s1_valid_r) begin
      out_sum_r       <= out_sum_nxt;
      out_row_end_r   <= s1_row_end_r;
      out_frame_end_r <= s1_frame_end_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_tile_sum  = out_sum_r;
  assign out_row_end   = out_row_end_r;
  assign out_frame_end = out_frame_end_r;

  // Checks
  `BSD_ASSERT_IMPL(a_stall_only_when_full, in_stall, s1_valid_r && out_valid_r && out_stall)
  `BSD_ASSERT_NEXT(a_emit_reaches_stage, in_fire && pos.emit, s1_valid_r)
  `BSD_ASSERT_NEXT(a_stage_moves_out, s1_valid_r && out_take, out_valid_r)
  `BSD_ASSERT_IMPL(a_frame_end_is_row_end, out_valid_r && out_frame_end_r, out_row_end_r)

endmodule

`default_nettype wire

// ===== verif/tb_block_sum_2x2_downsample_unit.sv =====
// Testbench: random and directed pixel streams into the 2x2 sum pooling block, scoreboarded.
`timescale 1ns / 1ps

module tb_block_sum_2x2_downsample_unit;
  import bsd_pkg::*;

  localparam int LIMIT         = 500000;
  localparam int SETTLE_CYCLES = 6;
  localparam int HOLD_CYCLES   = 400;
  localparam int RANDOM_PIXELS = 250;
  localparam int WIDE_EXTRA    = 32;
  localparam int TALL_PIXELS   = 160;

  // config register indexes the block has no register behind
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  localparam logic signed [DATA_BITS-1:0] PIX_MAX = {1'b0, {(DATA_BITS-1){1'b1}}};
  localparam logic signed [DATA_BITS-1:0] PIX_MIN = {1'b1, {(DATA_BITS-1){1'b0}}};

  typedef struct {
    logic signed [SUM_BITS-1:0] sum;
    logic                       row_end;
    logic                       frame_end;
  } tile_result_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic signed [DATA_BITS-1:0]   in_pixel = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic signed [SUM_BITS-1:0]    out_tile_sum;
  logic                          out_row_end;
  logic                          out_frame_end;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [CFG_IDX_W-1:0]          cfg_index = '0;
  logic [CFG_DATA_W-1:0]         cfg_data = '0;

  logic signed [DATA_BITS-1:0]   pixel_q [$];
  tile_result_t                  tile_q [$];
  int                            err_count = 0;
  int                            cycle_count = 0;
  bit                            steady = 1'b0;
  bit                            hold_req = 1'b0;

  // predictor state: size registers, raster position, pair line store
  logic [ROWS_CFG_W-1:0]         size_rows = ROWS_CFG_W'(1);
  logic [COLS_CFG_W-1:0]         size_cols = COLS_CFG_W'(1);
  int                            row_pos = 0;
  int                            col_pos = 0;
  logic signed [PAIR_BITS-1:0]   col_partial = '0;
  logic signed [PAIR_BITS-1:0]   pair_store [LINE_DEPTH] = '{default: '0};

  block_sum_2x2_downsample_unit u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_pixel      (in_pixel),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_tile_sum  (out_tile_sum),
    .out_row_end   (out_row_end),
    .out_frame_end (out_frame_end),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // zero reads as one, anything above the maximum as the maximum
  function automatic int clamp_size(input int val, input int limit);
    if (val == 0) return 1;
    if (val > limit) return limit;
    return val;
  endfunction

  // wait until every pixel is taken and every tile sum is back, then let the pipe settle
  task automatic drain();
    do @(negedge clk); while (pixel_q.size() != 0 || in_valid || tile_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic feed_random(input int count);
    int sel;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(99);
      if (sel < 10) pixel_q.push_back(PIX_MAX);
      else if (sel < 20) pixel_q.push_back(PIX_MIN);
      else pixel_q.push_back(DATA_BITS'($urandom));
    end
  endtask

  // pixel driver: a stalled beat holds, otherwise next pixel or a random gap
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (pixel_q.size() != 0 && (steady || $urandom_range(99) >= 33)) begin
        in_valid <= 1'b1;
        in_pixel <= pixel_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result side stall: random, off in steady stretches, one long hold-off on request
  always @(posedge clk) begin : sink_stall
    int  hold_left;
    bit  held;
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left = 0;
      held = 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (hold_req && !held) begin
      held = 1'b1;
      hold_left = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !steady && ($urandom_range(99) < 33);
    end
  end

  // predictor and checker
  always @(posedge clk) begin : scoreboard
    int           rows_eff, cols_eff, tile, pair_v, sum_v;
    bit           last_c, last_r, emit;
    tile_result_t want;
    if (rst_n) begin
      // size write restarts the frame, line store is kept
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_FRAME_ROWS || cfg_index == CFG_FRAME_COLS) begin
          if (cfg_index == CFG_FRAME_ROWS) size_rows = cfg_data[ROWS_CFG_W-1:0];
          else size_cols = cfg_data[COLS_CFG_W-1:0];
          row_pos = 0;
          col_pos = 0;
          col_partial = '0;
        end
      end

      // one pixel beat: build pair sums, park even-row pairs, emit completed tiles
      if (in_valid && !in_stall) begin
        rows_eff = clamp_size(int'(size_rows), MAX_ROWS);
        cols_eff = clamp_size(int'(size_cols), MAX_COLS);
        last_c = (col_pos + 1 >= cols_eff);
        last_r = (row_pos + 1 >= rows_eff);
        tile = (col_pos / 2) % LINE_DEPTH;
        emit = 1'b0;
        if (col_pos % 2 == 0) col_partial = PAIR_BITS'(in_pixel);
        if (col_pos % 2 == 1 || last_c) begin
          pair_v = (col_pos % 2 == 1) ? int'(col_partial) + int'(in_pixel) : int'(in_pixel);
          if (row_pos % 2 == 1) begin
            sum_v = int'(pair_store[tile]) + pair_v;
            emit = 1'b1;
          end else if (last_r) begin
            sum_v = pair_v;
            emit = 1'b1;
          end else begin
            pair_store[tile] = pair_v[PAIR_BITS-1:0];
          end
        end
        if (emit) begin
          want.sum = sum_v[SUM_BITS-1:0];
          want.row_end = last_c;
          want.frame_end = last_c && last_r;
          tile_q.push_back(want);
        end
        if (last_c) begin
          col_pos = 0;
          row_pos = last_r ? 0 : row_pos + 1;
        end else begin
          col_pos++;
        end
      end

      // result beat against oldest expectation
      if (out_valid && !out_stall) begin
        if (tile_q.size() == 0) begin
          err_count++;
          $display("%0t: unexpected beat, got sum %0d row_end %0b frame_end %0b",
                   $time, out_tile_sum, out_row_end, out_frame_end);
        end else begin
          want = tile_q.pop_front();
          if (out_tile_sum !== want.sum || out_row_end !== want.row_end ||
              out_frame_end !== want.frame_end) begin
            err_count++;
            $display("%0t: mismatch, expected sum/row/frame %0d/%0b/%0b, got %0d/%0b/%0b",
                     $time, want.sum, want.row_end, want.frame_end,
                     out_tile_sum, out_row_end, out_frame_end);
          end
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin : stimulus
    int                    n, frame_len, pick, cur_rows, cur_cols, random_items;
    logic [CFG_DATA_W-1:0] rows_val, cols_val;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset size is 1x1: every pixel is a full frame
    pixel_q.push_back(PIX_MIN);

    // 2x2 full tiles at both sum extremes, two frames back to back
    write_reg(CFG_FRAME_ROWS, 13'd2);
    write_reg(CFG_FRAME_COLS, 13'd2);
    repeat (4) pixel_q.push_back(PIX_MAX);
    repeat (4) pixel_q.push_back(PIX_MIN);

    // odd last row and odd last column give partial tiles
    write_reg(CFG_FRAME_ROWS, 13'd3);
    write_reg(CFG_FRAME_COLS, 13'd3);
    for (int i = 0; i < 9; i++) begin
      if (i % 3 == 0) pixel_q.push_back(PIX_MAX);
      else if (i % 3 == 1) pixel_q.push_back(PIX_MIN);
      else pixel_q.push_back(DATA_BITS'(i * 4099 - 16000));
    end

    // zero sizes behave as one
    write_reg(CFG_FRAME_ROWS, 13'd0);
    write_reg(CFG_FRAME_COLS, 13'd0);
    pixel_q.push_back(16'sh3039);

    // writes to unused indexes must not restart the frame
    write_reg(CFG_FRAME_ROWS, 13'd1);
    write_reg(CFG_FRAME_COLS, 13'd3);
    pixel_q.push_back(PIX_MAX);
    write_reg(CFG_SPARE_A, 13'h1FFF);
    pixel_q.push_back(PIX_MAX);
    pixel_q.push_back(PIX_MIN);
    write_reg(CFG_SPARE_B, '0);
    cur_rows = 1;
    cur_cols = 3;

    // random sizes; mostly whole frames, some cut short by the next write
    random_items = 0;
    while (random_items < RANDOM_PIXELS) begin
      pick = $urandom_range(2);
      if (pick != 2) begin
        n = $urandom_range(99);
        if (n < 70) rows_val = CFG_DATA_W'($urandom_range(6, 1));
        else if (n < 80) rows_val = '0;
        else if (n < 90) rows_val = CFG_DATA_W'($urandom_range(16, 7));
        else rows_val = CFG_DATA_W'($urandom_range(8191, MAX_ROWS + 1));
        write_reg(CFG_FRAME_ROWS, rows_val);
        cur_rows = int'(rows_val);
      end
      if (pick != 1) begin
        n = $urandom_range(99);
        if (n < 70) cols_val = CFG_DATA_W'($urandom_range(9, 1));
        else if (n < 80) cols_val = '0;
        else if (n < 90) cols_val = CFG_DATA_W'($urandom_range(40, 10));
        else cols_val = CFG_DATA_W'($urandom_range(2047, MAX_COLS + 1));
        // upper bits beyond the column field are don't-care
        cols_val[CFG_DATA_W-1:COLS_CFG_W] = (CFG_DATA_W - COLS_CFG_W)'($urandom_range(3));
        write_reg(CFG_FRAME_COLS, cols_val);
        cur_cols = int'(cols_val[COLS_CFG_W-1:0]);
      end
      frame_len = clamp_size(cur_rows, MAX_ROWS) * clamp_size(cur_cols, MAX_COLS);
      if (frame_len <= 120 && $urandom_range(99) < 80) n = frame_len * $urandom_range(3, 1);
      else n = $urandom_range(120, 1);
      feed_random(n);
      random_items += n;
    end

    // widest frame: the even row writes every line store entry, no idling on either side
    write_reg(CFG_FRAME_ROWS, 13'd2);
    write_reg(CFG_FRAME_COLS, 13'h1FFF);
    steady = 1'b1;
    feed_random(MAX_COLS + WIDE_EXTRA);
    drain();
    @(negedge clk);
    steady = 1'b0;

    // tall single-column frame, with a long hold-off on the result side while pixels keep coming
    write_reg(CFG_FRAME_ROWS, 13'h1FFF);
    write_reg(CFG_FRAME_COLS, 13'd1);
    feed_random(TALL_PIXELS);
    hold_req = 1'b1;

    drain();
    repeat (20) @(posedge clk);
    @(negedge clk);
    if (err_count == 0 && tile_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
